[rtl/core/vfg_pkg.sv]
`timescale 1ns / 1ps

package vfg_pkg;

    localparam int unsigned DIV_STAGES = 13;

    localparam logic [1:0] PT_BLANK    = 2'd0;
    localparam logic [1:0] PT_RESERVED = 2'd1;
    localparam logic [1:0] PT_RGB16    = 2'd2;
    localparam logic [1:0] PT_RGB32    = 2'd3;

    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_TWO  = 3'd2;
    localparam logic [2:0] BPP_FOUR = 3'd4;

    typedef struct packed {
        logic [23:0] addr;
        logic [11:0] width;
        logic [2:0]  bpp;
        logic        vis;
        logic        ok;
        logic [23:0] m;
    } t_front;

endpackage

[rtl/core/vfg_if.sv]
`timescale 1ns / 1ps

interface vfg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  pixel_type;
    logic        serrate;
    logic [23:0] origin;
    logic [11:0] line_width;
    logic [9:0]  h_start;
    logic [9:0]  h_end;
    logic [9:0]  v_start;
    logic [9:0]  v_end;
    logic [11:0] x_scale;
    logic [11:0] y_scale;
    logic [9:0]  current_line;

    modport source (
        output valid, pixel_type, serrate, origin, line_width, h_start, h_end,
               v_start, v_end, x_scale, y_scale, current_line,
        input  ready
    );
    modport sink (
        input  valid, pixel_type, serrate, origin, line_width, h_start, h_end,
               v_start, v_end, x_scale, y_scale, current_line,
        output ready
    );
endinterface

interface vfg_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] fb_address;
    logic [11:0] fb_width;
    logic [12:0] fb_height;
    logic [2:0]  bytes_per_pixel;
    logic        is_visible;

    modport source (
        output valid, fb_address, fb_width, fb_height, bytes_per_pixel, is_visible,
        input  ready
    );
    modport sink (
        input  valid, fb_address, fb_width, fb_height, bytes_per_pixel, is_visible,
        output ready
    );
endinterface

[rtl/core/vfg_front.sv]
`timescale 1ns / 1ps

module vfg_front
    import vfg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    vfg_in_if.sink       i_in,
    output logic         o_valid,
    input  logic         i_ready,
    output t_front       o_data
);

    logic en1, en2, en3;

    // stage 1
    logic               r1_v;
    logic [1:0]         r1_type;
    logic               r1_ser, r1_line0, r1_vis, r1_ys_nz, r1_vpos, r1_span_nz, r1_xs_nz;
    logic [23:0]        r1_origin;
    logic [11:0]        r1_lw;
    logic signed [23:0] r1_sx;
    logic [21:0]        r1_p;

    logic signed [10:0] n_span, n_vspan;
    logic signed [23:0] n_sx;

    // stage 2
    logic               r2_v;
    logic               r2_vis, r2_ok, r2_use;
    logic [23:0]        r2_origin;
    logic [11:0]        r2_dw;
    logic [2:0]         r2_bpp;
    logic [14:0]        r2_off;
    logic [33:0]        r2_q;

    logic signed [27:0] n_sxe, n_lhs, n_rhs;
    logic               n_half;
    logic [11:0]        n_dw;
    logic [2:0]         n_bpp;
    logic [1:0]         n_sh;
    logic [14:0]        n_off;

    // stage 3
    logic               r3_v;
    t_front             r3_d;
    logic [34:0]        n_sum;
    logic [23:0]        n_offe;

    assign en3 = !r3_v || i_ready;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_in.ready = en1;
    assign o_valid = r3_v;
    assign o_data  = r3_d;

    always_comb begin
        n_span  = signed'({1'b0, i_in.h_end}) - signed'({1'b0, i_in.h_start});
        n_vspan = signed'({1'b0, i_in.v_end}) - signed'({1'b0, i_in.v_start});
        n_sx    = n_span * signed'({1'b0, i_in.x_scale});
    end

    always_comb begin
        n_sxe  = 28'(r1_sx);
        n_lhs  = (n_sxe <<< 4) - n_sxe;
        n_rhs  = signed'({3'b000, r1_lw, 13'd0});
        n_half = r1_ser && r1_span_nz && r1_xs_nz && (n_lhs < n_rhs);
        n_dw   = n_half ? {1'b0, r1_lw[11:1]} : r1_lw;
        case (r1_type)
            PT_RGB16: n_bpp = BPP_TWO;
            PT_RGB32: n_bpp = BPP_FOUR;
            default:  n_bpp = BPP_NONE;
        endcase
        n_sh  = ((r1_type == PT_RGB32) ? 2'd2 : 2'd1) + ((r1_ser && r1_line0) ? 2'd1 : 2'd0);
        n_off = {3'b000, n_dw} << n_sh;
    end

    always_comb begin
        n_sum  = {1'b0, r2_q} + {13'd0, r2_dw, 10'd0};
        n_offe = {9'd0, r2_off};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_in.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
        end
        if (en1) begin
            r1_type    <= i_in.pixel_type;
            r1_ser     <= i_in.serrate;
            r1_line0   <= i_in.current_line[0];
            r1_vis     <= (i_in.pixel_type != PT_BLANK) && (i_in.h_start != 10'd0);
            r1_ys_nz   <= i_in.y_scale != 12'd0;
            r1_vpos    <= !n_vspan[10] && (n_vspan != 11'sd0);
            r1_span_nz <= n_span != 11'sd0;
            r1_xs_nz   <= i_in.x_scale != 12'd0;
            r1_origin  <= i_in.origin;
            r1_lw      <= i_in.line_width;
            r1_sx      <= n_sx;
            r1_p       <= n_vspan[9:0] * i_in.y_scale;
        end
        if (en2) begin
            r2_vis    <= r1_vis;
            r2_ok     <= (n_dw != 12'd0) && r1_ys_nz && r1_vpos;
            r2_use    <= (r1_type == PT_RGB16) || (r1_type == PT_RGB32);
            r2_origin <= r1_origin;
            r2_dw     <= n_dw;
            r2_bpp    <= n_bpp;
            r2_off    <= n_off;
            r2_q      <= r1_p * r1_lw;
        end
        if (en3) begin
            r3_d.addr  <= (r2_use && (r2_origin >= n_offe)) ? r2_origin - n_offe : r2_origin;
            r3_d.width <= r2_dw;
            r3_d.bpp   <= r2_bpp;
            r3_d.vis   <= r2_vis;
            r3_d.ok    <= r2_ok;
            r3_d.m     <= n_sum[34:11];
        end
    end

endmodule

[rtl/core/vfg_div.sv]
`timescale 1ns / 1ps

module vfg_div
    import vfg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_front                i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_front                o_data,
    output logic [DIV_STAGES-1:0] o_quo
);

    logic                  r_v   [DIV_STAGES];
    t_front                r_d   [DIV_STAGES];
    logic [23:0]           r_rem [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_quo [DIV_STAGES];
    logic                  en    [DIV_STAGES];

    always_comb begin
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            if (k == DIV_STAGES - 1) en[k] = !r_v[k] || i_ready;
            else                     en[k] = !r_v[k] || en[k + 1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_data  = r_d[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int unsigned BIT = DIV_STAGES - 1 - k;
        logic                  v_in;
        t_front                d_in;
        logic [23:0]           rem_in;
        logic [DIV_STAGES-1:0] quo_in;
        logic [24+BIT:0]       den;
        logic [24+BIT:0]       rem_x;
        logic                  take;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign d_in   = i_data;
            assign rem_in = i_data.m;
            assign quo_in = '0;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign d_in   = r_d[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign den   = {(13 + BIT)'(0), d_in.width} << BIT;
        assign rem_x = {(1 + BIT)'(0), rem_in};
        assign take  = rem_x >= den;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= v_in;
            end
            if (en[k]) begin
                r_d[k]   <= d_in;
                r_rem[k] <= take ? 24'(rem_x - den) : rem_in;
                r_quo[k] <= quo_in | (take ? (DIV_STAGES)'(1) << BIT : '0);
            end
        end
    end

endmodule

[rtl/core/video_framebuffer_geometry.sv]
`timescale 1ns / 1ps
// Framebuffer geometry from one snapshot of the video-interface registers.
// i_in (sink) takes a request of register values; o_out (source) returns one
// result per request: base address, shown width, padded height, pixel size
// and visibility. A request is taken on a clock edge with valid and ready high.
// Path from acceptance to o_out: 3 front stages, 13 stages of a
// one-bit-per-stage height divider, 1 output register.
// Throughput: one request per cycle; every stage holds its own valid bit.
// Requests enter whenever the first stage is empty or moving, so bubbles fill
// up while a result waits at the output.
// When the receiver stalls, stages fill up and i_in.ready drops once the
// pipeline is full; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is kept.
module video_framebuffer_geometry
    import vfg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    vfg_in_if.sink    i_in,
    vfg_out_if.source o_out
);

    logic                  f_valid, f_ready, d_valid, d_ready, en_o;
    t_front                f_data, d_data;
    logic [DIV_STAGES-1:0] d_quo;
    logic [12:0]           n_h;
    logic                  n_ok;
    logic                  r_ov;

    vfg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_data  (f_data)
    );

    vfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  (f_data),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_data  (d_data),
        .o_quo   (d_quo)
    );

    assign en_o    = !r_ov || o_out.ready;
    assign d_ready = en_o;
    assign o_out.valid = r_ov;

    always_comb begin
        n_ok = d_data.ok && (d_quo != '0);
        n_h  = (13'(d_quo) + 13'd4) & ~13'd3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= d_valid;
        end
        if (en_o) begin
            o_out.fb_address      <= d_data.addr;
            o_out.fb_width        <= n_ok ? d_data.width : 12'd0;
            o_out.fb_height       <= n_ok ? n_h : 13'd0;
            o_out.bytes_per_pixel <= d_data.bpp;
            o_out.is_visible      <= d_data.vis;
        end
    end

endmodule
